### hdl/cs_pkg.sv
// Shared constants and beat types for the cosine similarity block.
package cs_pkg;

    localparam int CS_ELEM_BITS = 16;
    localparam int CS_FRAC_BITS = 14;
    localparam int CS_SIM_BITS  = CS_FRAC_BITS + 2;
    localparam int CS_MAX_LEN   = 4096;

    typedef struct packed {
        logic signed [CS_ELEM_BITS-1:0] elem_a;
        logic signed [CS_ELEM_BITS-1:0] elem_b;
        logic                           last_elem;
    } cs_in_t;

    typedef struct packed {
        logic signed [CS_SIM_BITS-1:0] similarity;
        logic                          zero_norm;
    } cs_out_t;

    // Result handoff from the ratio sequencer to the output register
    typedef struct packed {
        logic    valid;
        cs_out_t data;
    } cs_res_t;

endpackage

### hdl/cosine_similarity_top.sv
// Top level of the streaming cosine similarity block.
//
//  channel   dir  handshake              beat
//  in        in   in_valid / in_ready    cs_in_t  (elem_a, elem_b, last_elem)
//  out       out  out_valid / out_ready  cs_out_t (similarity, zero_norm)
//
// Each element beat is captured, then takes three steps on the shared
// 16x16 multiplier (dot, a squared, b squared).
// After the last element the ratio search runs on one shift-add multiplier:
// two wide products, then up to 15 search steps of two products each; each
// product steps through the multiplier bits one at a time.
// Reset clears the sums and the sequencers; a waiting result holds in the
// output register while new element beats are already taken.
module cosine_similarity_top #(
    parameter int MAX_LEN = cs_pkg::CS_MAX_LEN
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cs_pkg::cs_in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output cs_pkg::cs_out_t out_data
);
    import cs_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN);
    localparam int DOT_W = (2*CS_ELEM_BITS + LEN_W) > 64 ? 64 : (2*CS_ELEM_BITS + LEN_W);
    localparam int SQ_W  = (2*CS_ELEM_BITS - 1 + LEN_W) > 64 ? 64 :
                           (2*CS_ELEM_BITS - 1 + LEN_W);

    logic             ratio_idle;
    logic             sums_start;
    logic [SQ_W-1:0]  sum_a, sum_b;
    logic [DOT_W-1:0] sum_dot;
    cs_res_t          res;
    logic             res_take;
    logic             out_valid_reg;
    cs_out_t          out_data_reg;

    cs_mac #(
        .MAX_LEN (MAX_LEN)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .ratio_idle (ratio_idle),
        .sums_start (sums_start),
        .sum_a      (sum_a),
        .sum_b      (sum_b),
        .sum_dot    (sum_dot)
    );

    cs_ratio #(
        .MAX_LEN (MAX_LEN)
    ) u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sums_start),
        .sum_a    (sum_a),
        .sum_b    (sum_b),
        .sum_dot  (sum_dot),
        .idle     (ratio_idle),
        .res_take (res_take),
        .res      (res)
    );

    // Move the result into the output register when it is free
    assign res_take = res.valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A zero norm result carries a zero similarity
    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_norm |-> out_data.similarity == '0)
        else $error("zero norm beat with nonzero similarity");

    // Similarity stays within plus or minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_data.similarity) <= $signed(CS_SIM_BITS'(1 << CS_FRAC_BITS))
                   && $signed(out_data.similarity) >= -$signed(CS_SIM_BITS'(1 << CS_FRAC_BITS))))
        else $error("similarity out of range");

    // No element beat is taken while the ratio search runs
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> ratio_idle)
        else $error("input ready during ratio search");

    // A result offered to a full, stalled output register stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && out_valid && !out_ready |=> res.valid)
        else $error("result dropped while output stalled");

endmodule

### hdl/cs_serial_mul.sv
// Shift-add multiplier: one partial product per cycle, stops when the multiplier runs out.
module cs_serial_mul #(
    parameter int A_W = 86,
    parameter int B_W = 44
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 done,
    output logic [A_W+B_W-1:0]   prod
);
    localparam int P_W = A_W + B_W;

    logic           busy_reg;
    logic [P_W-1:0] a_reg;
    logic [B_W-1:0] b_reg;
    logic [P_W-1:0] acc_reg;

    // Done once every set multiplier bit has been added in
    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

    // Track the busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Add the shifted multiplicand for each set bit, advance one bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= P_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

### hdl/cs_mac.sv
// Element accumulator: one shared multiplier forms the dot and square terms in turn.
module cs_mac #(
    parameter int MAX_LEN = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cs_pkg::cs_in_t         in_data,
    input  logic                   ratio_idle,
    output logic                   sums_start,
    output logic [((2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)) > 64 ? 64 :
                   (2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)))-1:0] sum_a,
    output logic [((2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)) > 64 ? 64 :
                   (2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)))-1:0] sum_b,
    output logic [((2*cs_pkg::CS_ELEM_BITS+$clog2(MAX_LEN)) > 64 ? 64 :
                   (2*cs_pkg::CS_ELEM_BITS+$clog2(MAX_LEN)))-1:0] sum_dot
);
    import cs_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN);
    localparam int DOT_W = (2*CS_ELEM_BITS + LEN_W) > 64 ? 64 : (2*CS_ELEM_BITS + LEN_W);
    localparam int SQ_W  = (2*CS_ELEM_BITS - 1 + LEN_W) > 64 ? 64 :
                           (2*CS_ELEM_BITS - 1 + LEN_W);
    localparam int PR_W  = 2*CS_ELEM_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DOT  = 2'd1;
    localparam logic [1:0] ST_SQA  = 2'd2;
    localparam logic [1:0] ST_SQB  = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic signed [CS_ELEM_BITS-1:0] a_reg, b_reg;
    logic                           last_reg;
    logic [DOT_W-1:0]               dot_reg, dot_next;
    logic [SQ_W-1:0]                sqa_reg, sqa_next;
    logic [SQ_W-1:0]                sqb_reg, sqb_next;
    logic signed [CS_ELEM_BITS-1:0] op_x, op_y;
    logic signed [PR_W-1:0]         prod;
    logic                           accept;

    assign in_ready = (state_reg == ST_IDLE) && ratio_idle;
    assign accept   = in_valid && in_ready;

    // Pick the operand pair for this phase
    always_comb
    begin
        case (state_reg)
            ST_DOT:
            begin
                op_x = a_reg;
                op_y = b_reg;
            end
            ST_SQA:
            begin
                op_x = a_reg;
                op_y = a_reg;
            end
            default:
            begin
                op_x = b_reg;
                op_y = b_reg;
            end
        endcase
    end

    assign prod = op_x * op_y;

    // Advance the phase; in each multiply phase update one sum per cycle
    always_comb
    begin
        state_next = state_reg;
        dot_next   = dot_reg;
        sqa_next   = sqa_reg;
        sqb_next   = sqb_reg;
        sums_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                dot_next   = dot_reg + DOT_W'(prod);
                state_next = ST_SQA;
            end
            ST_SQA:
            begin
                sqa_next   = sqa_reg + SQ_W'(prod[PR_W-2:0]);
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                sqb_next   = sqb_reg + SQ_W'(prod[PR_W-2:0]);
                sums_start = last_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hand the finished sums over on the last element
    assign sum_a   = sqa_reg;
    assign sum_b   = sqb_next;
    assign sum_dot = dot_reg;

    // Hold sums and phase; clear the sums once handed over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dot_reg   <= '0;
            sqa_reg   <= '0;
            sqb_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (sums_start)
            begin
                dot_reg <= '0;
                sqa_reg <= '0;
                sqb_reg <= '0;
            end
            else
            begin
                dot_reg <= dot_next;
                sqa_reg <= sqa_next;
                sqb_reg <= sqb_next;
            end
        end
    end

    // Capture the element beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= in_data.elem_a;
            b_reg    <= in_data.elem_b;
            last_reg <= in_data.last_elem;
        end
    end

endmodule

### hdl/cs_ratio.sv
// Ratio sequencer: binary search for the rounded cosine, products from the shared multiplier.
module cs_ratio #(
    parameter int MAX_LEN = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [((2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)) > 64 ? 64 :
                   (2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)))-1:0] sum_a,
    input  logic [((2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)) > 64 ? 64 :
                   (2*cs_pkg::CS_ELEM_BITS-1+$clog2(MAX_LEN)))-1:0] sum_b,
    input  logic [((2*cs_pkg::CS_ELEM_BITS+$clog2(MAX_LEN)) > 64 ? 64 :
                   (2*cs_pkg::CS_ELEM_BITS+$clog2(MAX_LEN)))-1:0] sum_dot,
    output logic             idle,
    input  logic             res_take,
    output cs_pkg::cs_res_t  res
);
    import cs_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN);
    localparam int DOT_W = (2*CS_ELEM_BITS + LEN_W) > 64 ? 64 : (2*CS_ELEM_BITS + LEN_W);
    localparam int SQ_W  = (2*CS_ELEM_BITS - 1 + LEN_W) > 64 ? 64 :
                           (2*CS_ELEM_BITS - 1 + LEN_W);
    localparam int Q_W   = CS_FRAC_BITS + 1;
    localparam int K2_W  = 2*Q_W;
    localparam int MA_W  = 2*SQ_W;
    localparam int MB_W  = DOT_W > K2_W ? DOT_W : K2_W;
    localparam int P_W   = MA_W + MB_W;
    localparam int SH_W  = 2*CS_FRAC_BITS + 2;
    localparam int C_W   = P_W > (2*DOT_W + SH_W) ? P_W : (2*DOT_W + SH_W);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_P  = 3'd1;
    localparam logic [2:0] ST_MUL_D  = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_MUL_K  = 3'd4;
    localparam logic [2:0] ST_MUL_L  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [DOT_W-1:0]  dmag_reg;
    logic              neg_reg, zero_reg;
    logic [MA_W-1:0]   p_reg;
    logic [2*DOT_W-1:0] d2_reg;
    logic [Q_W-1:0]    lo_reg, hi_reg, mid_reg;
    logic [Q_W:0]      span;
    logic [Q_W-1:0]    mid;
    logic [Q_W-1:0]    k;
    logic [DOT_W-1:0]  dmag;
    logic              zero_in;
    logic              mul_start, mul_done;
    logic [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [P_W-1:0]    mul_prod;
    logic              fits;
    logic [Q_W+1:0]    q_ext;
    logic [CS_SIM_BITS-1:0] q_sim;

    assign zero_in = (sum_a == '0) || (sum_b == '0);
    assign dmag    = sum_dot[DOT_W-1] ? (DOT_W'(0) - sum_dot) : sum_dot;

    // Midpoint rounded up and its odd test value 2*mid-1
    assign span = (Q_W+1)'(hi_reg - lo_reg) + (Q_W+1)'(1);
    assign mid  = lo_reg + Q_W'(span >> 1);
    assign k    = Q_W'({mid, 1'b0} - (Q_W+1)'(1));

    // Compare (2*mid-1)^2 * sa*sb against (d * 2^(F+1))^2
    assign fits = C_W'(mul_prod) <= (C_W'(d2_reg) << SH_W);

    assign idle = (state_reg == ST_IDLE);

    // Sequence the multiplies and the search
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (zero_in)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = MA_W'(sum_a);
                        mul_b      = MB_W'(sum_b);
                        state_next = ST_MUL_P;
                    end
                end
            end
            ST_MUL_P:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MA_W'(dmag_reg);
                    mul_b      = MB_W'(dmag_reg);
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                if (mul_done)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MA_W'(k);
                    mul_b      = MB_W'(k);
                    state_next = ST_MUL_K;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_K:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = p_reg;
                    mul_b      = MB_W'(mul_prod[K2_W-1:0]);
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                if (mul_done)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    cs_serial_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold operands, products and search bounds
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dmag_reg <= dmag;
                    neg_reg  <= sum_dot[DOT_W-1];
                    zero_reg <= zero_in;
                    lo_reg   <= '0;
                    hi_reg   <= Q_W'(1) << CS_FRAC_BITS;
                end
            end
            ST_MUL_P:
            begin
                if (mul_done)
                begin
                    p_reg <= mul_prod[MA_W-1:0];
                end
            end
            ST_MUL_D:
            begin
                if (mul_done)
                begin
                    d2_reg <= mul_prod[2*DOT_W-1:0];
                end
            end
            ST_SEARCH:
            begin
                mid_reg <= mid;
            end
            ST_MUL_L:
            begin
                if (mul_done)
                begin
                    if (fits)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg - Q_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Apply the dot product sign to the rounded magnitude
    assign q_ext = (Q_W+2)'(lo_reg);
    assign q_sim = neg_reg ? (CS_SIM_BITS'(0) - CS_SIM_BITS'(q_ext))
                           : CS_SIM_BITS'(q_ext);

    always_comb
    begin
        res.valid           = (state_reg == ST_DONE);
        res.data.similarity = zero_reg ? '0 : q_sim;
        res.data.zero_norm  = zero_reg;
    end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the streaming cosine similarity block.
`timescale 1ns / 100ps

module tb_top;
    import cs_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int IDLE_PCT = 30;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    cs_in_t  in_data;
    logic    out_valid;
    logic    out_ready = 1'b0;
    cs_out_t out_data;

    // Running sums mirrored at the block's widths
    logic [43:0] dot_sum;
    logic [42:0] sq_sum_a;
    logic [42:0] sq_sum_b;

    cs_out_t expected_sims[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    bit      steady;

    cosine_similarity_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Largest q in [0, 2^FRAC] with q - 1/2 <= d * 2^FRAC / sqrt(sa * sb)
    function automatic logic [15:0] rounded_cosine(input logic [43:0] d,
                                                   input logic [42:0] sa,
                                                   input logic [42:0] sb);
        logic [191:0] prod;
        logic [191:0] num;
        logic [191:0] rhs;
        logic [191:0] k;
        logic [191:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        prod = 192'(sa) * 192'(sb);
        num  = 192'(d) << (CS_FRAC_BITS + 1);
        rhs  = num * num;
        lo   = 0;
        hi   = 1 << CS_FRAC_BITS;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            k   = 192'(2 * mid - 1);
            lhs = k * k * prod;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 16'(lo);
    endfunction

    // Accumulate one element pair; on the last pair queue the cosine
    task automatic accumulate_pair(input cs_in_t beat);
        logic signed [43:0] wa;
        logic signed [43:0] wb;
        logic signed [43:0] dot_s;
        logic [43:0]        mag;
        logic [15:0]        q;
        cs_out_t            res;
        wa = beat.elem_a;
        wb = beat.elem_b;
        dot_sum  = dot_sum + 44'(wa * wb);
        sq_sum_a = sq_sum_a + 43'(wa * wa);
        sq_sum_b = sq_sum_b + 43'(wb * wb);
        if (beat.last_elem)
        begin
            dot_s = dot_sum;
            res.zero_norm = (sq_sum_a == 0) || (sq_sum_b == 0);
            if (res.zero_norm)
                q = 16'd0;
            else
            begin
                mag = dot_s < 0 ? -dot_s : dot_s;
                q = rounded_cosine(mag, sq_sum_a, sq_sum_b);
            end
            res.similarity = dot_s < 0 ? -q : q;
            expected_sims = {expected_sims, res};
            dot_sum  = '0;
            sq_sum_a = '0;
            sq_sum_b = '0;
        end
    endtask

    // Drive one beat, with an optional random gap ahead of it
    task automatic send_beat(input logic [15:0] a, input logic [15:0] b, input bit last);
        cs_in_t beat;
        beat.elem_a = a;
        beat.elem_b = b;
        beat.last_elem = last;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_pair(beat);
    endtask

    function automatic logic [15:0] random_elem(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(8) - 4);
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(600) - 300);
        endcase
    endfunction

    task automatic test_directed();
        send_beat(16'h7fff, 16'h7fff, 1'b1);   // identical max vectors
        send_beat(16'h8000, 16'h8000, 1'b1);   // identical min vectors
        send_beat(16'h7fff, 16'h8000, 1'b1);   // opposite extremes
        send_beat(16'h0000, 16'h0005, 1'b1);   // first norm zero
        send_beat(16'h0009, 16'h0000, 1'b1);   // second norm zero
        send_beat(16'h0000, 16'h0000, 1'b1);   // both norms zero
        send_beat(16'h0001, 16'h0000, 1'b0);   // orthogonal pair
        send_beat(16'h0000, 16'h0001, 1'b1);
        send_beat(16'h0001, 16'h0001, 1'b0);   // 45 degrees
        send_beat(16'h0000, 16'h0001, 1'b1);
        send_beat(16'h0003, 16'hfffd, 1'b0);   // mixed signs, tie-prone ratios
        send_beat(16'h0004, 16'h0005, 1'b0);
        send_beat(16'hffff, 16'h0002, 1'b1);
        send_beat(16'h5555, 16'haaaa, 1'b0);   // alternating bit patterns
        send_beat(16'haaaa, 16'h5555, 1'b1);
        send_beat(16'h0001, 16'h7fff, 1'b0);   // tiny against huge
        send_beat(16'h7fff, 16'h0001, 1'b1);
    endtask

    // Long vectors of extreme values drive the sums to large magnitudes
    task automatic test_long_vector();
        for (int i = 0; i < 120; i++)
            send_beat(16'h8000, 16'h8000, i == 119);
        for (int i = 0; i < 80; i++)
            send_beat(16'h7fff, 16'h8000, i == 79);
    endtask

    task automatic test_random(input int beats);
        int sent;
        int len;
        int mode;
        sent = 0;
        while (sent < beats)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
            mode = $urandom_range(3);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(7) == 0)
                    send_beat(random_elem(mode), 16'h0000, i == len - 1);
                else if (mode == 3 && $urandom_range(1))
                    send_beat(random_elem(mode), random_elem(mode), i == len - 1);
                else
                    send_beat(random_elem(mode), random_elem($urandom_range(3)),
                              i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_no_idle(input int beats);
        steady = 1'b1;
        test_random(beats);
        steady = 1'b0;
    endtask

    // Result checker and output stall
    always @(posedge clk)
    begin
        cs_out_t exp_res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sims.size() == 0)
                begin
                    $error("unexpected result similarity=%0d zero_norm=%0b",
                           out_data.similarity, out_data.zero_norm);
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_sims.pop_front();
                    if (out_data.similarity !== exp_res.similarity)
                    begin
                        $error("similarity expected %0d actual %0d",
                               exp_res.similarity, out_data.similarity);
                        mismatches++;
                    end
                    if (out_data.zero_norm !== exp_res.zero_norm)
                    begin
                        $error("zero_norm expected %0b actual %0b",
                               exp_res.zero_norm, out_data.zero_norm);
                        mismatches++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        steady      = 1'b0;
        dot_sum     = '0;
        sq_sum_a    = '0;
        sq_sum_b    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(520);
        test_no_idle(250);
        test_random(300);
        test_long_vector();
        test_random(60);

        in_valid <= 1'b0;
        while (expected_sims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
hdl/cs_pkg.sv
hdl/cs_serial_mul.sv
hdl/cs_mac.sv
hdl/cs_ratio.sv
hdl/cosine_similarity_top.sv
verif/tb_top.sv
